// ===== rtl/sbht_pkg.sv =====
package sbht_pkg;

    // Queue status seen by the front (space left) and the back (items waiting).
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } fifo_stat_t;

    // Number of box corners tested per request.
    localparam int unsigned CORNERS = 4;

endpackage

// ===== rtl/sbht_front.sv =====
module sbht_front
    import sbht_pkg::*;
#(
    parameter int unsigned COORD_BITS = 20
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [CORNERS*2*COORD_BITS-1:0]  in_data,
    input  fifo_stat_t                       stat,
    output logic                             push,
    output logic                             item_hit,
    output logic signed [2*COORD_BITS+4:0]   item_sum,
    output logic signed [2*COORD_BITS+2:0]   item_len2,
    output logic signed [COORD_BITS-1:0]     item_sx,
    output logic signed [COORD_BITS-1:0]     item_sy,
    output logic signed [COORD_BITS:0]       item_dx,
    output logic signed [COORD_BITS:0]       item_dy
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned DW = C + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned TW = PW + 1;
    localparam int unsigned SW = TW + 2;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [C-1:0] sx, sy, ex, ey, x0, y0, x1, y1;

    logic signed [C-1:0]  sx1_reg, sy1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, vx0_reg, vx1_reg, vy0_reg, vy1_reg;

    logic signed [C-1:0]  sx2_reg, sy2_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic signed [PW-1:0] dxdx_reg, dydy_reg;
    logic signed [PW-1:0] dxvy0_reg, dxvy1_reg, dyvx0_reg, dyvx1_reg;
    logic signed [PW-1:0] dxvx0_reg, dxvx1_reg, dyvy0_reg, dyvy1_reg;

    logic signed [C-1:0]  sx3_reg, sy3_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg;
    logic [CORNERS-1:0]   crneg_reg;
    logic signed [TW-1:0] dot_reg [CORNERS];
    logic signed [TW-1:0] len2_reg;

    logic signed [TW-1:0] cross_next [CORNERS];
    logic signed [TW-1:0] dot_next [CORNERS];
    logic [CORNERS-1:0]   behind, past;
    logic signed [TW:0]   rest [CORNERS];
    logic                 hit_next;
    logic signed [SW-1:0] sum_next;

    logic                 hit4_reg;
    logic signed [SW-1:0] sum4_reg;
    logic signed [TW-1:0] len24_reg;
    logic signed [C-1:0]  sx4_reg, sy4_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg;

    assign sx = in_data[0*C +: C];
    assign sy = in_data[1*C +: C];
    assign ex = in_data[2*C +: C];
    assign ey = in_data[3*C +: C];
    assign x0 = in_data[4*C +: C];
    assign y0 = in_data[5*C +: C];
    assign x1 = in_data[6*C +: C];
    assign y1 = in_data[7*C +: C];

    // Advance the whole front unless the last stage holds an item the queue cannot take.
    assign en       = !v4_reg || stat.not_full;
    assign in_ready = en;
    assign push     = v4_reg && stat.not_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Corner order: (xmin,ymin), (xmin,ymax), (xmax,ymin), (xmax,ymax).
    always_comb
    begin
        cross_next[0] = TW'(dxvy0_reg) - TW'(dyvx0_reg);
        cross_next[1] = TW'(dxvy1_reg) - TW'(dyvx0_reg);
        cross_next[2] = TW'(dxvy0_reg) - TW'(dyvx1_reg);
        cross_next[3] = TW'(dxvy1_reg) - TW'(dyvx1_reg);
        dot_next[0]   = TW'(dxvx0_reg) + TW'(dyvy0_reg);
        dot_next[1]   = TW'(dxvx0_reg) + TW'(dyvy1_reg);
        dot_next[2]   = TW'(dxvx1_reg) + TW'(dyvy0_reg);
        dot_next[3]   = TW'(dxvx1_reg) + TW'(dyvy1_reg);
    end

    always_comb
    begin
        for (int k = 0; k < CORNERS; k++)
        begin
            rest[k]   = (TW+1)'(len2_reg) - (TW+1)'(dot_reg[k]);
            behind[k] = dot_reg[k][TW-1];
            past[k]   = rest[k][TW];
        end
        sum_next = SW'(dot_reg[0]) + SW'(dot_reg[1]) + SW'(dot_reg[2]) + SW'(dot_reg[3]);
        hit_next = (len2_reg != '0) && (crneg_reg != '0) && !(&crneg_reg)
                   && !(&behind) && !(&past);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx1_reg   <= sx;
            sy1_reg   <= sy;
            dx1_reg   <= DW'(ex) - DW'(sx);
            dy1_reg   <= DW'(ey) - DW'(sy);
            vx0_reg   <= DW'(x0) - DW'(sx);
            vx1_reg   <= DW'(x1) - DW'(sx);
            vy0_reg   <= DW'(y0) - DW'(sy);
            vy1_reg   <= DW'(y1) - DW'(sy);

            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            dxdx_reg  <= dx1_reg * dx1_reg;
            dydy_reg  <= dy1_reg * dy1_reg;
            dxvy0_reg <= dx1_reg * vy0_reg;
            dxvy1_reg <= dx1_reg * vy1_reg;
            dyvx0_reg <= dy1_reg * vx0_reg;
            dyvx1_reg <= dy1_reg * vx1_reg;
            dxvx0_reg <= dx1_reg * vx0_reg;
            dxvx1_reg <= dx1_reg * vx1_reg;
            dyvy0_reg <= dy1_reg * vy0_reg;
            dyvy1_reg <= dy1_reg * vy1_reg;

            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            len2_reg  <= TW'(dxdx_reg) + TW'(dydy_reg);
            for (int k = 0; k < CORNERS; k++)
            begin
                crneg_reg[k] <= cross_next[k][TW-1];
                dot_reg[k]   <= dot_next[k];
            end

            hit4_reg  <= hit_next;
            sum4_reg  <= sum_next;
            len24_reg <= len2_reg;
            sx4_reg   <= sx3_reg;
            sy4_reg   <= sy3_reg;
            dx4_reg   <= dx3_reg;
            dy4_reg   <= dy3_reg;
        end
    end

    assign item_hit  = hit4_reg;
    assign item_sum  = sum4_reg;
    assign item_len2 = len24_reg;
    assign item_sx   = sx4_reg;
    assign item_sy   = sy4_reg;
    assign item_dx   = dx4_reg;
    assign item_dy   = dy4_reg;

endmodule

// ===== rtl/sbht_queue.sv =====
module sbht_queue
    import sbht_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_stat_t       stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != CW'(DEPTH));
    assign pop_data       = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/sbht_back.sv =====
module sbht_back
    import sbht_pkg::*;
#(
    parameter int unsigned COORD_BITS = 20
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  fifo_stat_t                     stat,
    output logic                           pop,
    input  logic                           item_hit,
    input  logic signed [2*COORD_BITS+4:0] item_sum,
    input  logic signed [2*COORD_BITS+2:0] item_len2,
    input  logic signed [COORD_BITS-1:0]   item_sx,
    input  logic signed [COORD_BITS-1:0]   item_sy,
    input  logic signed [COORD_BITS:0]     item_dx,
    input  logic signed [COORD_BITS:0]     item_dy,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_hit,
    output logic signed [COORD_BITS-1:0]   out_x,
    output logic signed [COORD_BITS-1:0]   out_y
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned DW = C + 1;
    localparam int unsigned TW = 2 * DW + 1;
    localparam int unsigned SW = TW + 2;
    localparam int unsigned H  = (SW + 1) / 2;
    localparam int unsigned HW = SW - H;
    localparam int unsigned NW = SW + DW + 1;
    localparam int unsigned QB = C + 4;
    localparam int unsigned MW = TW + 2 + QB;
    localparam int unsigned RW = QB + 2;

    logic en;
    logic b1_v_reg, b2_v_reg, b3_v_reg, out_v_reg;

    // Stage 1: magnitudes and result signs.
    logic [SW-1:0]        ms_reg;
    logic [DW-1:0]        mdx_reg, mdy_reg;
    logic [TW-1:0]        l1_reg, l2_reg;
    logic                 nx1_reg, ny1_reg, h1_reg;
    logic signed [C-1:0]  sx1_reg, sy1_reg;

    // Stage 2: split products.
    logic [H+DW-1:0]      plx_reg, ply_reg;
    logic [HW+DW-1:0]     phx_reg, phy_reg;
    logic                 nx2_reg, ny2_reg, h2_reg;
    logic signed [C-1:0]  sx2_reg, sy2_reg;

    // Divider pipeline, index 0 is the stage 3 output.
    logic [MW-1:0]        rx_reg [QB+1];
    logic [MW-1:0]        ry_reg [QB+1];
    logic [QB-1:0]        qx_reg [QB+1];
    logic [QB-1:0]        qy_reg [QB+1];
    logic [MW-1:0]        den_reg [QB+1];
    logic                 nx_reg [QB+1];
    logic                 ny_reg [QB+1];
    logic                 h_reg [QB+1];
    logic signed [C-1:0]  sx_reg [QB+1];
    logic signed [C-1:0]  sy_reg [QB+1];
    logic                 dv_reg [QB+1];

    logic                 hit_reg;
    logic signed [C-1:0]  x_reg, y_reg;

    logic [SW-1:0]        ms_next;
    logic [DW-1:0]        mdx_next, mdy_next;
    logic signed [RW-1:0] ox, oy, rx_sum, ry_sum;

    function automatic logic signed [C-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        hi = RW'({1'b0, {(C-1){1'b1}}});
        lo = -hi - RW'(1);
        if (v > hi)
            sat = hi[C-1:0];
        else if (v < lo)
            sat = lo[C-1:0];
        else
            sat = v[C-1:0];
    endfunction

    // Advance the back unless the output register holds a result not yet taken.
    assign en        = !out_v_reg || out_ready;
    assign pop       = stat.not_empty && en;
    assign out_valid = out_v_reg;
    assign out_hit   = hit_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

    assign ms_next  = item_sum[SW-1] ? SW'(-item_sum) : SW'(item_sum);
    assign mdx_next = item_dx[DW-1] ? DW'(-item_dx) : DW'(item_dx);
    assign mdy_next = item_dy[DW-1] ? DW'(-item_dy) : DW'(item_dy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            b3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_v_reg  <= pop;
            b2_v_reg  <= b1_v_reg;
            b3_v_reg  <= b2_v_reg;
            out_v_reg <= dv_reg[QB];
        end
    end

    assign dv_reg[0] = b3_v_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ms_reg  <= ms_next;
            mdx_reg <= mdx_next;
            mdy_reg <= mdy_next;
            l1_reg  <= item_len2;
            nx1_reg <= item_sum[SW-1] ^ item_dx[DW-1];
            ny1_reg <= item_sum[SW-1] ^ item_dy[DW-1];
            h1_reg  <= item_hit;
            sx1_reg <= item_sx;
            sy1_reg <= item_sy;

            plx_reg <= ms_reg[H-1:0] * mdx_reg;
            ply_reg <= ms_reg[H-1:0] * mdy_reg;
            phx_reg <= ms_reg[SW-1:H] * mdx_reg;
            phy_reg <= ms_reg[SW-1:H] * mdy_reg;
            l2_reg  <= l1_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            h2_reg  <= h1_reg;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;

            // Add half the divisor so the quotient rounds to nearest.
            rx_reg[0]  <= MW'(plx_reg) + (MW'(phx_reg) << H) + (MW'(l2_reg) << 1);
            ry_reg[0]  <= MW'(ply_reg) + (MW'(phy_reg) << H) + (MW'(l2_reg) << 1);
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            den_reg[0] <= MW'(l2_reg) << 2;
            nx_reg[0]  <= nx2_reg;
            ny_reg[0]  <= ny2_reg;
            h_reg[0]   <= h2_reg;
            sx_reg[0]  <= sx2_reg;
            sy_reg[0]  <= sy2_reg;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar g = 0; g < QB; g++)
    begin : g_div
        localparam int unsigned SH = QB - 1 - g;
        logic [MW-1:0] trial;
        logic          take_x, take_y;

        assign trial  = den_reg[g] << SH;
        assign take_x = (rx_reg[g] >= trial);
        assign take_y = (ry_reg[g] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[g+1] <= 1'b0;
            else if (en)
                dv_reg[g+1] <= dv_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[g+1]  <= take_x ? rx_reg[g] - trial : rx_reg[g];
                ry_reg[g+1]  <= take_y ? ry_reg[g] - trial : ry_reg[g];
                qx_reg[g+1]  <= qx_reg[g] | (QB'(take_x) << SH);
                qy_reg[g+1]  <= qy_reg[g] | (QB'(take_y) << SH);
                den_reg[g+1] <= den_reg[g];
                nx_reg[g+1]  <= nx_reg[g];
                ny_reg[g+1]  <= ny_reg[g];
                h_reg[g+1]   <= h_reg[g];
                sx_reg[g+1]  <= sx_reg[g];
                sy_reg[g+1]  <= sy_reg[g];
            end
        end
    end

    assign ox     = nx_reg[QB] ? -RW'(qx_reg[QB]) : RW'(qx_reg[QB]);
    assign oy     = ny_reg[QB] ? -RW'(qy_reg[QB]) : RW'(qy_reg[QB]);
    assign rx_sum = RW'(sx_reg[QB]) + ox;
    assign ry_sum = RW'(sy_reg[QB]) + oy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= h_reg[QB];
            x_reg   <= h_reg[QB] ? sat(rx_sum) : '0;
            y_reg   <= h_reg[QB] ? sat(ry_sum) : '0;
        end
    end

    // Remainders below the last stage are not needed.
    logic unused_rem;
    assign unused_rem = ^{rx_reg[QB], ry_reg[QB], den_reg[QB]};

endmodule

// ===== rtl/segment_box_hit_test.sv =====
// Segment against axis-aligned box hit test, fully pipelined.
//
// Slave stream: one request per beat, s_tdata carries the segment start and end
// and the box edges. Master stream: one result per request, in order; m_tuser
// is the hit flag and m_tdata the hit point (zero when there is no hit).
//
// Throughput: one request per cycle sustained while m_tready stays high. On the way
// from input handshake to m_tvalid a request passes through four front
// stages (differences, products, cross and dot sums, classification), one
// queue write, three back stages (magnitudes, split products, numerator) and
// one divider stage per quotient bit (COORD_BITS + 4), then the output register.
// The restoring divider pipeline sets the latency.
//
// Reset clears every valid flag and the queue pointers; no result is presented
// until a new request arrives. When the receiver holds m_tready low, the back
// pipeline stops, the queue fills, then the front stops and s_tready drops.
// No request is lost or repeated.
module segment_box_hit_test
    import sbht_pkg::*;
#(
    parameter int unsigned COORD_BITS  = 20,
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_x_min, box_y_min,
    // box_x_max, box_y_max; COORD_BITS each, zero pad to bytes
    input  logic [((CORNERS*2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // hit_x, hit_y; COORD_BITS each, zero pad to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]            m_tdata,
    // hit
    output logic                                         m_tuser
);

    localparam int unsigned C     = COORD_BITS;
    localparam int unsigned DW    = C + 1;
    localparam int unsigned TW    = 2 * DW + 1;
    localparam int unsigned SW    = TW + 2;
    localparam int unsigned IW    = CORNERS * 2 * C;
    localparam int unsigned OW    = ((2 * C + 7) / 8) * 8;
    localparam int unsigned EW    = 1 + SW + TW + 2 * C + 2 * DW;

    fifo_stat_t stat;
    logic       push, pop;

    logic                 f_hit;
    logic signed [SW-1:0] f_sum;
    logic signed [TW-1:0] f_len2;
    logic signed [C-1:0]  f_sx, f_sy;
    logic signed [DW-1:0] f_dx, f_dy;

    logic [EW-1:0]        q_in, q_out;

    logic                 o_hit;
    logic signed [C-1:0]  o_x, o_y;

    logic unused_pad;
    assign unused_pad = ^s_tdata;

    sbht_front #(.COORD_BITS(C)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[IW-1:0]),
        .stat      (stat),
        .push      (push),
        .item_hit  (f_hit),
        .item_sum  (f_sum),
        .item_len2 (f_len2),
        .item_sx   (f_sx),
        .item_sy   (f_sy),
        .item_dx   (f_dx),
        .item_dy   (f_dy)
    );

    assign q_in = {f_dy, f_dx, f_sy, f_sx, f_len2, f_sum, f_hit};

    sbht_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .pop       (pop),
        .pop_data  (q_out),
        .stat      (stat)
    );

    sbht_back #(.COORD_BITS(C)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop       (pop),
        .item_hit  (q_out[0]),
        .item_sum  (q_out[1 +: SW]),
        .item_len2 (q_out[1+SW +: TW]),
        .item_sx   (q_out[1+SW+TW +: C]),
        .item_sy   (q_out[1+SW+TW+C +: C]),
        .item_dx   (q_out[1+SW+TW+2*C +: DW]),
        .item_dy   (q_out[1+SW+TW+2*C+DW +: DW]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (o_hit),
        .out_x     (o_x),
        .out_y     (o_y)
    );

    assign m_tuser = o_hit;
    assign m_tdata = OW'({o_y, o_x});

endmodule
